@@ rtl/ssrm_pkg.sv @@
// Shared types and constants for the site search and window merge block.
package ssrm_pkg;

   localparam int MAX_SITE_BYTES = 8;
   localparam int POSITION_BITS  = 32;
   localparam int WIN_BITS       = 31;
   localparam int LEN_BITS       = 4;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 2;
   localparam int OUT_DEPTH      = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SITE_PATTERN = 2'd0,
      CSR_SITE_LENGTH  = 2'd1,
      CSR_HALF_WINDOW  = 2'd2,
      CSR_SEQ_LENGTH   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] base;
      logic       last_base;
   } ssrm_req_type;

   typedef struct packed {
      logic [WIN_BITS-1:0] window_start;
      logic [WIN_BITS-1:0] window_end;
      logic                window_valid;
      logic [WIN_BITS-1:0] hit_total;
      logic                final_result;
   } ssrm_rsp_type;

   // Control flags of one item as it moves down the pipeline.
   typedef struct packed {
      logic valid;
      logic hit;
      logic last;
   } ssrm_flags_type;

endpackage

@@ rtl/ssrm_cell.sv @@
// One byte cell of the match chain: holds a byte and its fill flag, compares one pattern byte.
module ssrm_cell import ssrm_pkg::*; #(
   parameter int AGE = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift_en,
   input  logic                     clear,
   input  logic [7:0]               byte_in,
   input  logic                     filled_in,
   input  logic [CSR_DATA_BITS-1:0] pattern,
   input  logic [LEN_BITS-1:0]      site_len,
   output logic [7:0]               byte_out,
   output logic                     filled_out,
   output logic                     match_ok
);

   logic [7:0]          byte_ff;
   logic                filled_ff;
   logic [LEN_BITS-1:0] sel_wide;
   logic                active;
   logic [7:0]          pat_byte;

   // Age a lines up with pattern byte len-1-a.
   assign sel_wide = site_len - LEN_BITS'(AGE) - LEN_BITS'(1);
   assign active   = LEN_BITS'(AGE) < site_len;
   assign pat_byte = 8'(pattern >> {sel_wide[2:0], 3'b000});
   assign match_ok = !active || (filled_in && (byte_in == pat_byte));

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
      end else if (shift_en) begin
         filled_ff <= clear ? 1'b0 : filled_in;
      end
   end

   assign byte_out   = byte_ff;
   assign filled_out = filled_ff;

endmodule

@@ rtl/ssrm_merge.sv @@
// Window bounds stage and pending-window merge stage.
module ssrm_merge import ssrm_pkg::*; #(
   parameter int POSITION_BITS = ssrm_pkg::POSITION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  ssrm_flags_type           a_flags,
   input  logic [POSITION_BITS-1:0] a_pos,
   input  logic [WIN_BITS-1:0]      half_window,
   input  logic [WIN_BITS-1:0]      seq_length,
   output logic [1:0]               push_count,
   output ssrm_rsp_type             push_data0,
   output ssrm_rsp_type             push_data1
);

   localparam int SUM_BITS = 33;

   logic [SUM_BITS-1:0]      ext_p;
   logic [SUM_BITS-1:0]      ext_h;
   logic [SUM_BITS-1:0]      ext_seq;
   logic [SUM_BITS-1:0]      diff;
   logic [SUM_BITS-1:0]      sum;
   logic [POSITION_BITS-1:0] ws_calc;
   logic [WIN_BITS-1:0]      we_calc;

   ssrm_flags_type           b_flags_ff;
   logic [POSITION_BITS-1:0] b_ws_ff;
   logic [WIN_BITS-1:0]      b_we_ff;

   logic [WIN_BITS-1:0] ps_ff, ps_in;
   logic [WIN_BITS-1:0] pe_ff, pe_in;
   logic                pv_ff, pv_in;
   logic [WIN_BITS-1:0] hc_ff, hc_in;
   ssrm_rsp_type        final_rsp;
   logic                joins;

   // Window bounds for the hit position.
   assign ext_p   = SUM_BITS'(a_pos);
   assign ext_h   = SUM_BITS'(half_window);
   assign ext_seq = SUM_BITS'(seq_length);
   assign diff    = ext_p - ext_h;
   assign sum     = ext_p + ext_h;
   assign ws_calc = (ext_p < ext_h) ? '0 : POSITION_BITS'(diff);
   assign we_calc = (sum > ext_seq) ? seq_length : WIN_BITS'(sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_flags_ff <= '0;
      end else if (advance) begin
         b_flags_ff <= a_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_ws_ff <= ws_calc;
         b_we_ff <= we_calc;
      end
   end

   assign joins = pv_ff && (SUM_BITS'(b_ws_ff) <= SUM_BITS'(pe_ff));

   always_comb begin
      ps_in      = ps_ff;
      pe_in      = pe_ff;
      pv_in      = pv_ff;
      hc_in      = hc_ff;
      push_count = 2'd0;
      push_data0 = '0;
      push_data1 = '0;
      final_rsp  = '0;
      if (advance && b_flags_ff.valid) begin
         if (b_flags_ff.hit) begin
            if (hc_ff != '1) begin
               hc_in = hc_ff + WIN_BITS'(1);
            end
            if (joins) begin
               pe_in = b_we_ff;
            end else begin
               // Close the pending window before opening the new one.
               if (pv_ff) begin
                  push_data0.window_start = ps_ff;
                  push_data0.window_end   = pe_ff;
                  push_data0.window_valid = 1'b1;
                  push_count              = 2'd1;
               end
               ps_in = WIN_BITS'(b_ws_ff);
               pe_in = b_we_ff;
               pv_in = 1'b1;
            end
         end
         if (b_flags_ff.last) begin
            final_rsp.final_result = 1'b1;
            if (pv_in) begin
               final_rsp.window_start = ps_in;
               final_rsp.window_end   = pe_in;
               final_rsp.window_valid = 1'b1;
               final_rsp.hit_total    = hc_in;
            end
            if (push_count == 2'd0) begin
               push_data0 = final_rsp;
            end else begin
               push_data1 = final_rsp;
            end
            push_count = push_count + 2'd1;
            ps_in      = '0;
            pe_in      = '0;
            pv_in      = 1'b0;
            hc_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff <= '0;
         pe_ff <= '0;
         pv_ff <= 1'b0;
         hc_ff <= '0;
      end else begin
         ps_ff <= ps_in;
         pe_ff <= pe_in;
         pv_ff <= pv_in;
         hc_ff <= hc_in;
      end
   end

   a_push_needs_advance: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> advance)
      else $error("result pushed while the pipeline is held");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (advance && b_flags_ff.valid && b_flags_ff.last) |-> (push_count != 2'd0))
      else $error("final byte produced no result");

endmodule

@@ rtl/ssrm_out_fifo.sv @@
// Result queue: takes up to two results a cycle, hands out one per transfer.
module ssrm_out_fifo import ssrm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   push_count,
   input  ssrm_rsp_type push_data0,
   input  ssrm_rsp_type push_data1,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ssrm_rsp_type rsp_data
);

   localparam int PTR_BITS = $clog2(OUT_DEPTH);
   localparam int CNT_BITS = $clog2(OUT_DEPTH + 1);

   ssrm_rsp_type        entry_ff [OUT_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                pop;

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // Hold the pipeline unless two more results would fit.
   assign room      = count_ff <= CNT_BITS'(OUT_DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in  = count_ff + CNT_BITS'(push_count) - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_BITS'(1)] <= push_data1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(OUT_DEPTH))
      else $error("result queue overflow");

endmodule

@@ rtl/site_search_range_merge_top.sv @@
// Top level: configuration registers, byte cell chain, hit stage, merge and result queue.
// A result passes from its byte's transfer through the hit stage, window bounds stage and
// result queue to rsp_; req_stall can hold it in the stages between.
// Throughput: one byte per cycle while req_stall is low; it rises only while the queue
// holds more than two results, as the two merge stages and the queue advance together.
// Reset (synchronous, active high) clears the sequence state, pipeline, queue and
// configuration to pattern 0, site length 4, half window 0, sequence length 1.
module site_search_range_merge_top import ssrm_pkg::*; #(
   parameter int MAX_SITE_BYTES = ssrm_pkg::MAX_SITE_BYTES,
   parameter int POSITION_BITS  = ssrm_pkg::POSITION_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ssrm_req_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ssrm_rsp_type              rsp_data,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [CSR_DATA_BITS-1:0] site_pattern_ff;
   logic [LEN_BITS-1:0]      site_length_ff;
   logic [WIN_BITS-1:0]      half_window_ff;
   logic [WIN_BITS-1:0]      seq_length_ff;

   logic                     advance;
   logic                     accept;
   logic [LEN_BITS-1:0]      len_eff;
   logic                     hit;
   logic                     clear;
   logic [POSITION_BITS-1:0] pos_ff;
   logic [POSITION_BITS-1:0] hit_pos;

   logic [7:0]                chain_byte   [MAX_SITE_BYTES];
   logic                      chain_filled [MAX_SITE_BYTES];
   logic [MAX_SITE_BYTES-1:0] cell_ok;

   ssrm_flags_type           a_flags_ff;
   logic [POSITION_BITS-1:0] a_pos_ff;

   logic [1:0]   push_count;
   ssrm_rsp_type push_data0;
   ssrm_rsp_type push_data1;
   logic         room;

   always_ff @(posedge clock) begin
      if (reset) begin
         site_pattern_ff <= '0;
         site_length_ff  <= LEN_BITS'(4);
         half_window_ff  <= '0;
         seq_length_ff   <= WIN_BITS'(1);
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SITE_PATTERN: site_pattern_ff <= csr_wdata;
            CSR_SITE_LENGTH:  site_length_ff  <= csr_wdata[LEN_BITS-1:0];
            CSR_HALF_WINDOW:  half_window_ff  <= csr_wdata[WIN_BITS-1:0];
            CSR_SEQ_LENGTH:   seq_length_ff   <= csr_wdata[WIN_BITS-1:0];
         endcase
      end
   end

   assign advance   = room;
   assign req_stall = !room;
   assign accept    = req_valid && advance;

   assign len_eff = (site_length_ff > LEN_BITS'(MAX_SITE_BYTES)) ?
                    LEN_BITS'(MAX_SITE_BYTES) : site_length_ff;

   assign chain_byte[0]   = req_data.base;
   assign chain_filled[0] = 1'b1;

   for (genvar i = 0; i < MAX_SITE_BYTES; i++) begin : g_cell
      if (i < MAX_SITE_BYTES - 1) begin : g_mid
         ssrm_cell #(.AGE(i)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (accept),
            .clear      (clear),
            .byte_in    (chain_byte[i]),
            .filled_in  (chain_filled[i]),
            .pattern    (site_pattern_ff),
            .site_len   (len_eff),
            .byte_out   (chain_byte[i+1]),
            .filled_out (chain_filled[i+1]),
            .match_ok   (cell_ok[i])
         );
      end else begin : g_end
         ssrm_cell #(.AGE(i)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (accept),
            .clear      (clear),
            .byte_in    (chain_byte[i]),
            .filled_in  (chain_filled[i]),
            .pattern    (site_pattern_ff),
            .site_len   (len_eff),
            .byte_out   (),
            .filled_out (),
            .match_ok   (cell_ok[i])
         );
      end
   end

   assign hit     = (len_eff != '0) && (&cell_ok);
   // A hit or the end of a sequence empties the chain.
   assign clear   = hit || req_data.last_base;
   assign hit_pos = pos_ff + POSITION_BITS'(1) - POSITION_BITS'(len_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept) begin
         pos_ff <= req_data.last_base ? '0 : pos_ff + POSITION_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_flags_ff <= '0;
      end else if (advance) begin
         a_flags_ff.valid <= req_valid;
         a_flags_ff.hit   <= req_valid && hit;
         a_flags_ff.last  <= req_valid && req_data.last_base;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_pos_ff <= hit_pos;
      end
   end

   ssrm_merge #(.POSITION_BITS(POSITION_BITS)) u_merge (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .a_flags     (a_flags_ff),
      .a_pos       (a_pos_ff),
      .half_window (half_window_ff),
      .seq_length  (seq_length_ff),
      .push_count  (push_count),
      .push_data0  (push_data0),
      .push_data1  (push_data1)
   );

   ssrm_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data0 (push_data0),
      .push_data1 (push_data1),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   a_hit_reaches_stage: assert property (@(posedge clock) disable iff (reset)
      (accept && hit) |=> a_flags_ff.hit)
      else $error("accepted hit lost before the merge stage");

endmodule
